>>> sv/bthin_pkg.sv
package bthin_pkg;

  localparam int MAX_ROWS = 256;
  localparam int MAX_COLS = 256;

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = 2 ** ADDR_W;
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W = $clog2(MAX_COLS + 1);

  // three image rows of taps: two full row delays plus the 3-pixel window
  localparam int LINE_LEN = 2 * MAX_COLS + 3;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_RUN   = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;

  typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_SCAN, ST_DRAIN, ST_DONE} state_t;
  typedef enum logic [1:0] {DIR_N, DIR_S, DIR_E, DIR_W} dir_t;

  // p1..p8 run counterclockwise from the northeast neighbor
  function automatic logic clear_pixel(dir_t dir, logic ctr, logic p1, logic p2,
                                       logic p3, logic p4, logic p5, logic p6,
                                       logic p7, logic p8);
    logic nb;
    logic [3:0] cnt;
    logic keep;
    unique case (dir)
      DIR_N: nb = p2;
      DIR_S: nb = p6;
      DIR_E: nb = p8;
      DIR_W: nb = p4;
    endcase
    cnt = 4'(p1) + 4'(p2) + 4'(p3) + 4'(p4) + 4'(p5) + 4'(p6) + 4'(p7) + 4'(p8);
    keep = (p2 & ~p4 & ~p8 & (p5 | p6 | p7)) |
           (p6 & ~p4 & ~p8 & (p1 | p2 | p3)) |
           (p8 & ~p2 & ~p6 & (p3 | p4 | p5)) |
           (p4 & ~p2 & ~p6 & (p7 | p8 | p1)) |
           (p5 & ~p4 & ~p6) | (p7 & ~p6 & ~p8) |
           (p1 & ~p8 & ~p2) | (p3 & ~p2 & ~p4);
    return ctr & ~nb & (cnt >= 4'd2) & ~keep;
  endfunction

endpackage

>>> sv/bthin_ram.sv
module bthin_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/bthin_cell.sv
module bthin_cell (
  input  logic clk,
  input  logic en,
  input  logic d,
  output logic q
);

  logic q_r;

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

>>> sv/binary_image_thinning.sv
// channel | direction | handshake      | payload
// in_     | input     | valid / stall  | action, row, col, pixel_in
// out_    | output    | valid / stall  | pixel_out, pass_count, is_run_done
// cfg_    | input     | valid / ready  | index, data
// A pixel write is done on acceptance; a read moves to ST_READ and waits there for the output register.
// A run sweeps rows_in_use x MAX_COLS pixels and then drains the window pipeline in each sub-pass,
// four sub-passes per pass, repeated until a pass clears nothing; the single
// image memory port pair and the row-delay cell chain set that pixel-by-pixel sweep.
// Synchronous active-low reset clears control state; the image is undefined until written.
// in_stall is high whenever a command is in progress; out_stall holds the result register.
module binary_image_thinning (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_action,
  input  logic [7:0] in_row,
  input  logic [7:0] in_col,
  input  logic       in_pixel_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_pixel_out,
  output logic [7:0] out_pass_count,
  output logic       out_is_run_done,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);

  localparam int M = bthin_pkg::MAX_COLS;

  bthin_pkg::state_t state_r, state_nxt;
  bthin_pkg::dir_t   dir_r, dir_nxt;

  logic [8:0] rows_cfg_r, cols_cfg_r;
  logic [bthin_pkg::RCNT_W-1:0] rows_eff;
  logic [bthin_pkg::CCNT_W-1:0] cols_eff;

  logic [bthin_pkg::ROW_W-1:0] sr_r, sr_nxt, t1r_r, t2r_r;
  logic [bthin_pkg::COL_W-1:0] sc_r, sc_nxt, t1c_r, t2c_r;
  logic v1_r, v2_r, issue;

  logic changed_r, changed_nxt;
  logic [7:0] passes_r, passes_nxt;

  logic [bthin_pkg::ADDR_W-1:0] addr_r, addr_nxt, host_addr, raddr, sweep_addr, waddr;
  logic inside_r, inside_nxt, in_inside, in_accept;
  logic host_we, sweep_we, ram_we, ram_wdata, rdata;

  logic out_valid_r, out_valid_nxt, out_pix_r, out_pix_nxt, out_done_r, out_done_nxt;
  logic [7:0] out_cnt_r, out_cnt_nxt;
  logic out_free;

  logic [bthin_pkg::LINE_LEN-1:0] line;
  logic interior;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= 9'd256;
      cols_cfg_r <= 9'd256;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == bthin_pkg::REG_ROWS) rows_cfg_r <= cfg_data;
      if (cfg_index == bthin_pkg::REG_COLS) cols_cfg_r <= cfg_data;
    end
  end

  assign rows_eff = (int'(rows_cfg_r) > bthin_pkg::MAX_ROWS) ?
                    bthin_pkg::RCNT_W'(bthin_pkg::MAX_ROWS) : bthin_pkg::RCNT_W'(rows_cfg_r);
  assign cols_eff = (int'(cols_cfg_r) > bthin_pkg::MAX_COLS) ?
                    bthin_pkg::CCNT_W'(bthin_pkg::MAX_COLS) : bthin_pkg::CCNT_W'(cols_cfg_r);

  assign in_stall  = (state_r != bthin_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign in_inside = (int'(in_row) < bthin_pkg::MAX_ROWS) && (int'(in_col) < bthin_pkg::MAX_COLS);
  assign host_addr = {bthin_pkg::ROW_W'(in_row), bthin_pkg::COL_W'(in_col)};
  assign out_free  = !out_valid_r || !out_stall;

  // chain of row-delay cells, newest pixel at position zero
  for (genvar i = 0; i < bthin_pkg::LINE_LEN; i++) begin : g_line
    if (i == 0) begin : g_head
      bthin_cell u_cell (.clk(clk), .en(v1_r), .d(rdata), .q(line[i]));
    end else begin : g_body
      bthin_cell u_cell (.clk(clk), .en(v1_r), .d(line[i-1]), .q(line[i]));
    end
  end

  // window center sits one row and one column behind the newest pixel
  assign interior = v2_r && (int'(t2r_r) >= 2) && (int'(t2c_r) >= 2) &&
                    (int'(t2c_r) < int'(cols_eff));
  assign sweep_we = interior &&
                    bthin_pkg::clear_pixel(dir_r, line[M+1], line[2*M], line[2*M+1],
                                           line[2*M+2], line[M+2], line[2], line[1],
                                           line[0], line[M]);
  assign sweep_addr = {t2r_r - bthin_pkg::ROW_W'(1), t2c_r - bthin_pkg::COL_W'(1)};

  assign ram_we    = host_we || sweep_we;
  assign waddr     = sweep_we ? sweep_addr : host_addr;
  assign ram_wdata = sweep_we ? 1'b0 : in_pixel_in;

  bthin_ram #(.WIDTH(1), .DEPTH(bthin_pkg::DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(waddr), .wdata(ram_wdata), .raddr(raddr), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bthin_pkg::ST_IDLE;
      dir_r       <= bthin_pkg::DIR_N;
      changed_r   <= 1'b0;
      passes_r    <= 8'd0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dir_r       <= dir_nxt;
      changed_r   <= changed_nxt;
      passes_r    <= passes_nxt;
      v1_r        <= issue;
      v2_r        <= v1_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sr_r      <= sr_nxt;
    sc_r      <= sc_nxt;
    t1r_r     <= sr_r;
    t1c_r     <= sc_r;
    t2r_r     <= t1r_r;
    t2c_r     <= t1c_r;
    addr_r    <= addr_nxt;
    inside_r  <= inside_nxt;
    out_pix_r <= out_pix_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_done_r <= out_done_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    dir_nxt       = dir_r;
    sr_nxt        = sr_r;
    sc_nxt        = sc_r;
    issue         = 1'b0;
    changed_nxt   = changed_r | sweep_we;
    passes_nxt    = passes_r;
    host_we       = 1'b0;
    raddr         = addr_r;
    addr_nxt      = addr_r;
    inside_nxt    = inside_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_pix_nxt   = out_pix_r;
    out_cnt_nxt   = out_cnt_r;
    out_done_nxt  = out_done_r;
    unique case (state_r)
      bthin_pkg::ST_IDLE: begin
        raddr = host_addr;
        if (in_accept) begin
          unique case (in_action)
            bthin_pkg::ACT_WRITE: host_we = in_inside;
            bthin_pkg::ACT_READ: begin
              addr_nxt   = host_addr;
              inside_nxt = in_inside;
              state_nxt  = bthin_pkg::ST_READ;
            end
            bthin_pkg::ACT_RUN: begin
              dir_nxt     = bthin_pkg::DIR_N;
              sr_nxt      = '0;
              sc_nxt      = '0;
              changed_nxt = 1'b0;
              passes_nxt  = 8'd0;
              state_nxt   = bthin_pkg::ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      bthin_pkg::ST_READ: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = inside_r & rdata;
          out_cnt_nxt   = 8'd0;
          out_done_nxt  = 1'b0;
          state_nxt     = bthin_pkg::ST_IDLE;
        end
      end
      bthin_pkg::ST_SCAN: begin
        issue = 1'b1;
        raddr = {sr_r, sc_r};
        if (sc_r == bthin_pkg::COL_W'(M - 1)) begin
          sc_nxt = '0;
          if (int'(sr_r) + 1 >= int'(rows_eff)) begin
            state_nxt = bthin_pkg::ST_DRAIN;
          end else begin
            sr_nxt = sr_r + bthin_pkg::ROW_W'(1);
          end
        end else begin
          sc_nxt = sc_r + bthin_pkg::COL_W'(1);
        end
      end
      bthin_pkg::ST_DRAIN: begin
        // hold until the last window has been decided and written back
        if (!v1_r && !v2_r) begin
          sr_nxt = '0;
          sc_nxt = '0;
          if (dir_r == bthin_pkg::DIR_W) begin
            if (passes_r != 8'hFF) passes_nxt = passes_r + 8'd1;
            if (changed_r) begin
              changed_nxt = 1'b0;
              dir_nxt     = bthin_pkg::DIR_N;
              state_nxt   = bthin_pkg::ST_SCAN;
            end else begin
              state_nxt = bthin_pkg::ST_DONE;
            end
          end else begin
            dir_nxt   = bthin_pkg::dir_t'(dir_r + 2'd1);
            state_nxt = bthin_pkg::ST_SCAN;
          end
        end
      end
      bthin_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = 1'b0;
          out_cnt_nxt   = passes_r;
          out_done_nxt  = 1'b1;
          state_nxt     = bthin_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bthin_pkg::ST_IDLE;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_out   = out_pix_r;
  assign out_pass_count  = out_cnt_r;
  assign out_is_run_done = out_done_r;

`ifndef ASSERT_OFF
  a_window_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (state_r == bthin_pkg::ST_SCAN || state_r == bthin_pkg::ST_DRAIN))
    else $error("window valid outside a sweep");
  a_done_counts: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bthin_pkg::ST_DONE |-> passes_r != 8'd0)
    else $error("run finished with zero passes");
  a_clear_marks: assert property (@(posedge clk) disable iff (!rst_n)
    sweep_we |=> changed_r)
    else $error("cleared pixel not recorded");
  a_no_host_write: assert property (@(posedge clk) disable iff (!rst_n)
    sweep_we |-> !host_we)
    else $error("host write during sweep");
`endif

endmodule
